### hw/rtl/amhc_pkg.sv
// ----------------------------------------------------------------------------
// amhc_pkg: shared types and constants for the moisture averaging core
// Register indexes, register reset values, sequencer states and fixed widths.
// ----------------------------------------------------------------------------
package amhc_pkg;

	// Configuration register indexes
	localparam logic [2:0] REG_SAMPLE_COUNT   = 3'd0;
	localparam logic [2:0] REG_PUMP_ON_LEVEL  = 3'd1;
	localparam logic [2:0] REG_PUMP_OFF_LEVEL = 3'd2;
	localparam logic [2:0] REG_CALIB_WET      = 3'd3;
	localparam logic [2:0] REG_CALIB_DRY      = 3'd4;

	// Register reset values
	localparam logic [7:0]  RST_SAMPLE_COUNT   = 8'd10;
	localparam logic [11:0] RST_PUMP_ON_LEVEL  = 12'd2800;
	localparam logic [11:0] RST_PUMP_OFF_LEVEL = 12'd1800;
	localparam logic [11:0] RST_CALIB_WET      = 12'd1420;
	localparam logic [11:0] RST_CALIB_DRY      = 12'd3030;

	// Fixed field widths
	localparam int LEVEL_W   = 12;
	localparam int COUNT_W   = 8;
	localparam int PCT_W     = 7;
	localparam int PCT_NUM_W = 19;  // 4095 * 100 fits in 19 bits

	localparam logic [PCT_W-1:0] PCT_FULL  = 7'd100;
	localparam logic [PCT_W-1:0] PCT_EMPTY = 7'd0;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,   // taking samples
		ST_MEAN,   // divider working on sum / count
		ST_CLAMP,  // pump update, calibration clamps
		ST_SCALE,  // launch the percent division
		ST_PCT,    // divider working on percent
		ST_DONE    // waiting for the output register
	} amhc_state_t;

endpackage

### hw/rtl/amhc_div.sv
// ----------------------------------------------------------------------------
// amhc_div: shared restoring divider
// Unsigned divide, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module amhc_div #(
	parameter int N = 20,   // dividend and quotient width
	parameter int D = 12    // divisor width
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [N-1:0] dividend,
	input  logic [D-1:0] divisor,
	output logic         done,
	output logic [N-1:0] quotient
);

	localparam int CNT_W = $clog2(N + 1);

	logic [N-1:0]     dq_q;     // dividend shifting out, quotient shifting in
	logic [D-1:0]     rem_q;
	logic [D-1:0]     dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [D:0]   trial;
	logic [D+1:0] diff;
	logic         fits;

	// Trial subtract of the divisor from the shifted remainder
	always_comb begin
		trial = {rem_q, dq_q[N-1]};
		diff  = {1'b0, trial} - {2'b00, dvs_q};
		fits  = ~diff[D+1];
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(N);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1))
					busy_q <= 1'b0;
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dq_q  <= {dq_q[N-2:0], fits};
			rem_q <= fits ? diff[D-1:0] : trial[D-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = dq_q;

`ifndef SYNTHESIS
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider started while busy");
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy_q))
		else $error("divider done without work");
	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> rem_q < dvs_q)
		else $error("divider remainder out of range");
`endif

endmodule

### hw/rtl/averaged_moisture_hysteresis_control_core.sv
// ----------------------------------------------------------------------------
// averaged_moisture_hysteresis_control_core: block average and pump control
// Averages sample_count sensor samples, reports mean, moisture percent and
// the hysteresis pump state once per block.
// ----------------------------------------------------------------------------
// A sample that does not complete a block is taken and the core is ready
// again at once. A sample that completes a block starts the block work:
// one restoring divider of N = max(SAMPLE_BITS + 8, 19) bits, producing
// one quotient bit a cycle, is used first for sum / count and then, unless
// the mean is clamped at a calibration point, for the percent interpolation.
// Meanwhile sample_stall is high. The finished result sits in an output
// register, so the next block can start while it waits to be taken.
// Configuration writes are always accepted (cfg_ready is tied high) and
// must only be made while the core is idle; unknown indexes are ignored.
module averaged_moisture_hysteresis_control_core
	import amhc_pkg::*;
#(
	parameter int SAMPLE_BITS = 12
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// configuration writes
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [2:0]             cfg_index,
	input  logic [15:0]            cfg_data,
	// sample requests
	input  logic                   sample_valid,
	output logic                   sample_stall,
	input  logic [SAMPLE_BITS-1:0] sample,
	// result requests
	output logic                   result_valid,
	input  logic                   result_stall,
	output logic [LEVEL_W-1:0]     mean_reading,
	output logic [PCT_W-1:0]       moisture_percent,
	output logic                   pump_on
);

	localparam int SUM_W = SAMPLE_BITS + COUNT_W;
	localparam int DIV_N = (SUM_W > PCT_NUM_W) ? SUM_W : PCT_NUM_W;
	localparam int CMP_W = (SAMPLE_BITS > LEVEL_W) ? SAMPLE_BITS : LEVEL_W;

	amhc_state_t state_q, state_d;

	// configuration
	logic [COUNT_W-1:0] sample_count_q;
	logic [LEVEL_W-1:0] pump_on_level_q;
	logic [LEVEL_W-1:0] pump_off_level_q;
	logic [LEVEL_W-1:0] calib_wet_q;
	logic [LEVEL_W-1:0] calib_dry_q;

	// block state
	logic [SUM_W-1:0]       sum_q;
	logic [COUNT_W-1:0]     taken_q;
	logic                   pump_q;
	logic [SAMPLE_BITS-1:0] mean_q;
	logic [LEVEL_W-1:0]     diff_q;
	logic [LEVEL_W-1:0]     span_q;
	logic [PCT_W-1:0]       pct_q;

	// output register
	logic               result_valid_q;
	logic [LEVEL_W-1:0] mean_out_q;
	logic [PCT_W-1:0]   pct_out_q;
	logic               pump_out_q;

	logic               sample_take;
	logic [SUM_W-1:0]   sum_next;
	logic [COUNT_W-1:0] taken_next;
	logic [COUNT_W-1:0] target;
	logic               block_end;
	logic [CMP_W-1:0]   mean_ext;
	logic               at_wet;
	logic               at_dry;
	logic [PCT_NUM_W-1:0] pct_num;
	logic               out_free;

	logic               div_start;
	logic [DIV_N-1:0]   div_dividend;
	logic [LEVEL_W-1:0] div_divisor;
	logic               div_done;
	logic [DIV_N-1:0]   div_quot;

	// Accumulation and block end detect
	always_comb begin
		sample_take = sample_valid && !sample_stall;
		sum_next    = sum_q + SUM_W'(sample);
		taken_next  = taken_q + COUNT_W'(1);
		target      = (sample_count_q == '0) ? COUNT_W'(1) : sample_count_q;
		block_end   = taken_next >= target;
	end

	// Calibration compares and percent numerator (diff * 100 by shift and add)
	always_comb begin
		mean_ext = CMP_W'(mean_q);
		at_wet   = mean_ext <= CMP_W'(calib_wet_q);
		at_dry   = mean_ext >= CMP_W'(calib_dry_q);
		pct_num  = (PCT_NUM_W'(diff_q) << 6) + (PCT_NUM_W'(diff_q) << 5)
			+ (PCT_NUM_W'(diff_q) << 2);
		out_free = !result_valid_q || !result_stall;
	end

	// Divider operand select
	always_comb begin
		if (state_q == ST_IDLE) begin
			div_dividend = DIV_N'(sum_next);
			div_divisor  = LEVEL_W'(taken_next);
		end else begin
			div_dividend = DIV_N'(pct_num);
			div_divisor  = span_q;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (sample_take && block_end) state_d = ST_MEAN;
			ST_MEAN:  if (div_done) state_d = ST_CLAMP;
			ST_CLAMP: state_d = (at_wet || at_dry) ? ST_DONE : ST_SCALE;
			ST_SCALE: state_d = ST_PCT;
			ST_PCT:   if (div_done) state_d = ST_DONE;
			ST_DONE:  if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		sample_stall = 1'b1;
		div_start    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				sample_stall = 1'b0;
				div_start    = sample_valid && block_end;
			end
			ST_SCALE: div_start = 1'b1;
			default: begin
				sample_stall = 1'b1;
				div_start    = 1'b0;
			end
		endcase
	end

	amhc_div #(
		.N (DIV_N),
		.D (LEVEL_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quot)
	);

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_count_q   <= RST_SAMPLE_COUNT;
			pump_on_level_q  <= RST_PUMP_ON_LEVEL;
			pump_off_level_q <= RST_PUMP_OFF_LEVEL;
			calib_wet_q      <= RST_CALIB_WET;
			calib_dry_q      <= RST_CALIB_DRY;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SAMPLE_COUNT:   sample_count_q   <= cfg_data[COUNT_W-1:0];
				REG_PUMP_ON_LEVEL:  pump_on_level_q  <= cfg_data[LEVEL_W-1:0];
				REG_PUMP_OFF_LEVEL: pump_off_level_q <= cfg_data[LEVEL_W-1:0];
				REG_CALIB_WET:      calib_wet_q      <= cfg_data[LEVEL_W-1:0];
				REG_CALIB_DRY:      calib_dry_q      <= cfg_data[LEVEL_W-1:0];
				default: ;
			endcase
		end
	end

	// Control state: sequencer, accumulator, pump, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			sum_q          <= '0;
			taken_q        <= '0;
			pump_q         <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (sample_take) begin
				sum_q   <= block_end ? '0 : sum_next;
				taken_q <= block_end ? '0 : taken_next;
			end
			// on-level test first, so overlapping levels turn the pump on
			if (state_q == ST_CLAMP) begin
				if (mean_ext >= CMP_W'(pump_on_level_q))
					pump_q <= 1'b1;
				else if (mean_ext <= CMP_W'(pump_off_level_q))
					pump_q <= 1'b0;
			end
			if (state_q == ST_DONE && out_free)
				result_valid_q <= 1'b1;
			else if (result_valid_q && !result_stall)
				result_valid_q <= 1'b0;
		end
	end

	// Result datapath
	always_ff @(posedge clk) begin
		if (state_q == ST_MEAN && div_done)
			mean_q <= div_quot[SAMPLE_BITS-1:0];
		if (state_q == ST_CLAMP) begin
			diff_q <= LEVEL_W'(CMP_W'(calib_dry_q) - mean_ext);
			span_q <= calib_dry_q - calib_wet_q;
			pct_q  <= at_wet ? PCT_FULL : PCT_EMPTY;
		end
		if (state_q == ST_PCT && div_done)
			pct_q <= div_quot[PCT_W-1:0];
		if (state_q == ST_DONE && out_free) begin
			mean_out_q <= LEVEL_W'(mean_ext);
			pct_out_q  <= pct_q;
			pump_out_q <= pump_q;
		end
	end

	assign result_valid     = result_valid_q;
	assign mean_reading     = mean_out_q;
	assign moisture_percent = pct_out_q;
	assign pump_on          = pump_out_q;

`ifndef SYNTHESIS
	a_div_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_MEAN || state_q == ST_PCT))
		else $error("divider finished outside a wait state");
	a_acc_clear_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> (taken_q == '0 && sum_q == '0))
		else $error("accumulator not cleared during block processing");
	a_mean_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MEAN && div_done) |-> (div_quot >> SAMPLE_BITS) == '0)
		else $error("mean quotient overflows sample width");
	a_pct_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> moisture_percent <= PCT_FULL)
		else $error("moisture percent above full scale");
`endif

endmodule

### bench/averaged_moisture_hysteresis_control_core_test.sv
// ----------------------------------------------------------------------------
// averaged_moisture_hysteresis_control_core_test: self-checking bench
// A directed table hits calibration edges, pump level ties, a zero or lowered
// block size and ignored register indexes. Random phases then reprogram the
// registers and stream samples under four pacing modes. Every block result is
// compared with an in-bench model of the averaging and the pump hysteresis, or with the value given in the table row.
// ----------------------------------------------------------------------------
module averaged_moisture_hysteresis_control_core_test
	import amhc_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int SAMPLE_W      = 12;
	localparam int SETTLE_CYCLES = 64;     // one block of divider work plus margin
	localparam int DRAIN_LIMIT   = 20000;
	localparam int PHASES        = 12;
	localparam logic [SAMPLE_W-1:0] FULL_SCALE = '1;

	typedef struct packed {
		logic [LEVEL_W-1:0] mean;
		logic [PCT_W-1:0]   pct;
		logic               pump;
	} reading_t;

	typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_t;

	typedef struct packed {
		row_kind_t kind;
		logic [2:0]  index;
		logic [15:0] data;    // register data, or the sample in the low bits
		logic        typed;   // expected result given in the row
		reading_t    want;
	} plan_row_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [2:0]          cfg_index = '0;
	logic [15:0]         cfg_data = '0;
	logic                sample_valid = 1'b0;
	logic                sample_stall;
	logic [SAMPLE_W-1:0] sample = '0;
	logic                result_valid;
	logic                result_stall = 1'b0;
	logic [LEVEL_W-1:0]  mean_reading;
	logic [PCT_W-1:0]    moisture_percent;
	logic                pump_on;

	// register copies and block state of the model
	logic [COUNT_W-1:0] block_size;
	logic [LEVEL_W-1:0] on_level, off_level, wet_point, dry_point;
	logic [19:0]        block_sum;
	logic [COUNT_W-1:0] block_fill;
	logic               pump_running;

	reading_t  pending_readings[$];
	plan_row_t plan[$];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int drift_base = 2048;
	int samples_sent = 0;
	int readings_checked = 0;
	int writes_done = 0;
	int fail_count = 0;

	averaged_moisture_hysteresis_control_core #(.SAMPLE_BITS(SAMPLE_W)) dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.sample_valid    (sample_valid),
		.sample_stall    (sample_stall),
		.sample          (sample),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.mean_reading    (mean_reading),
		.moisture_percent(moisture_percent),
		.pump_on         (pump_on)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("Test completed with failures");
		$finish;
	end

	// ---------------------------------------------------------------- model

	function automatic logic [PCT_W-1:0] moisture_of(input logic [LEVEL_W-1:0] m);
		int num;
		int span;
		if (m <= wet_point)
			return PCT_FULL;
		if (m >= dry_point)
			return PCT_EMPTY;
		num = (int'(dry_point) - int'(m)) * 100;
		span = int'(dry_point) - int'(wet_point);
		return PCT_W'(num / span);
	endfunction

	task automatic load_register(input logic [2:0] idx, input logic [15:0] d);
		case (idx)
			REG_SAMPLE_COUNT:   block_size = d[COUNT_W-1:0];
			REG_PUMP_ON_LEVEL:  on_level = d[LEVEL_W-1:0];
			REG_PUMP_OFF_LEVEL: off_level = d[LEVEL_W-1:0];
			REG_CALIB_WET:      wet_point = d[LEVEL_W-1:0];
			REG_CALIB_DRY:      dry_point = d[LEVEL_W-1:0];
			default: ;
		endcase
	endtask

	// add one sample to the block; a full block queues its expected reading
	task automatic accumulate_sample(input logic [SAMPLE_W-1:0] s);
		logic [COUNT_W-1:0] needed;
		logic [LEVEL_W-1:0] m;
		reading_t r;
		block_sum += 20'(s);
		block_fill += 1'b1;
		needed = (block_size == '0) ? COUNT_W'(1) : block_size;
		if (block_fill >= needed) begin
			m = LEVEL_W'(block_sum / block_fill);
			block_sum = '0;
			block_fill = '0;
			// turn-on test wins when the levels overlap
			if (m >= on_level)
				pump_running = 1'b1;
			else if (m <= off_level)
				pump_running = 1'b0;
			r.mean = m;
			r.pct = moisture_of(m);
			r.pump = pump_running;
			pending_readings.push_back(r);
		end
	endtask

	// ------------------------------------------------------------ drivers

	task automatic send_sample(input logic [SAMPLE_W-1:0] s);
		cfg_valid <= 1'b0;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			sample_valid <= 1'b0;
			@(posedge clk);
		end
		sample_valid <= 1'b1;
		sample <= s;
		@(posedge clk);
		while (sample_stall)
			@(posedge clk);
		samples_sent++;
		accumulate_sample(s);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		writes_done++;
		load_register(idx, d);
	endtask

	// let every queued reading come back, then let the divider go quiet
	task automatic wait_idle();
		int n;
		sample_valid <= 1'b0;
		cfg_valid <= 1'b0;
		n = 0;
		while (pending_readings.size() != 0 && n < DRAIN_LIMIT) begin
			@(posedge clk);
			n++;
		end
		if (pending_readings.size() != 0) begin
			$error("%0d expected readings never arrived", pending_readings.size());
			fail_count++;
			pending_readings.delete();
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// ------------------------------------------------------------ checker

	always @(posedge clk) begin
		reading_t e;
		if (result_valid && !result_stall) begin
			if (pending_readings.size() == 0) begin
				$error("reading with none expected: mean %0d pct %0d pump %0d",
					mean_reading, moisture_percent, pump_on);
				fail_count++;
			end else begin
				e = pending_readings.pop_front();
				readings_checked++;
				if (mean_reading !== e.mean) begin
					$error("mean_reading: expected %0d, got %0d", e.mean, mean_reading);
					fail_count++;
				end
				if (moisture_percent !== e.pct) begin
					$error("moisture_percent: expected %0d, got %0d", e.pct, moisture_percent);
					fail_count++;
				end
				if (pump_on !== e.pump) begin
					$error("pump_on: expected %0d, got %0d", e.pump, pump_on);
					fail_count++;
				end
			end
		end
		result_stall <= ($urandom_range(0, 99) < recv_stall_pct);
	end

	// ------------------------------------------------------------ stimulus

	function automatic plan_row_t wr(input logic [2:0] idx, input logic [15:0] d);
		return '{ROW_WRITE, idx, d, 1'b0, '0};
	endfunction

	function automatic plan_row_t smp(input logic [SAMPLE_W-1:0] s);
		return '{ROW_SAMPLE, 3'd0, 16'(s), 1'b0, '0};
	endfunction

	function automatic plan_row_t smp_is(input logic [SAMPLE_W-1:0] s,
			input logic [LEVEL_W-1:0] m, input logic [PCT_W-1:0] p, input logic pump);
		return '{ROW_SAMPLE, 3'd0, 16'(s), 1'b1, '{m, p, pump}};
	endfunction

	function automatic logic [LEVEL_W-1:0] pick_level();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return LEVEL_W'($urandom_range(0, 4095));
		endcase
	endfunction

	// samples mostly hover around a wandering level so means cross thresholds
	function automatic logic [SAMPLE_W-1:0] next_sample();
		int v;
		case ($urandom_range(0, 15))
			0: return '0;
			1: return FULL_SCALE;
			2: return SAMPLE_W'($urandom_range(0, 4095));
			default: begin
				if ($urandom_range(0, 7) == 0)
					drift_base = $urandom_range(0, 4095);
				v = drift_base + $urandom_range(0, 127) - 64;
				if (v < 0)
					v = 0;
				if (v > 4095)
					v = 4095;
				return SAMPLE_W'(v);
			end
		endcase
	endfunction

	task automatic program_phase(input int p);
		logic [COUNT_W-1:0] cnt;
		logic [LEVEL_W-1:0] a, b, c, d;
		if (p == 0)
			cnt = '1;
		else if (p == 1)
			cnt = '0;
		else if (p == 2)
			cnt = COUNT_W'(1);
		else
			cnt = COUNT_W'($urandom_range(1, 12));
		a = pick_level();
		b = pick_level();
		c = pick_level();
		d = pick_level();
		// mostly on above off and wet below dry, sometimes the other way
		if ($urandom_range(0, 3) != 0 && a < b) begin
			a ^= b;
			b ^= a;
			a ^= b;
		end
		if ($urandom_range(0, 3) != 0 && c > d) begin
			c ^= d;
			d ^= c;
			c ^= d;
		end
		write_reg(REG_SAMPLE_COUNT, {8'($urandom), cnt});
		write_reg(REG_PUMP_ON_LEVEL, {4'($urandom), a});
		write_reg(REG_PUMP_OFF_LEVEL, {4'($urandom), b});
		write_reg(REG_CALIB_WET, {4'($urandom), c});
		write_reg(REG_CALIB_DRY, {4'($urandom), d});
		if ($urandom_range(0, 2) == 0)
			write_reg(3'($urandom_range(5, 7)), 16'($urandom));
	endtask

	initial begin
		plan_row_t row;
		logic after_sample;
		int items;

		block_size = RST_SAMPLE_COUNT;
		on_level = RST_PUMP_ON_LEVEL;
		off_level = RST_PUMP_OFF_LEVEL;
		wet_point = RST_CALIB_WET;
		dry_point = RST_CALIB_DRY;
		block_sum = '0;
		block_fill = '0;
		pump_running = 1'b0;

		// single-sample blocks: scale ends, calibration points, pump levels
		plan.push_back(wr(REG_SAMPLE_COUNT, 16'hA501));
		plan.push_back(smp_is(12'd0, 12'd0, 7'd100, 1'b0));
		plan.push_back(smp_is(12'd4095, 12'd4095, 7'd0, 1'b1));
		plan.push_back(smp(12'd2000));
		plan.push_back(smp(12'd1800));
		plan.push_back(smp_is(12'd1420, 12'd1420, 7'd100, 1'b0));
		plan.push_back(smp_is(12'd3030, 12'd3030, 7'd0, 1'b1));
		plan.push_back(smp(12'd3029));
		plan.push_back(smp(12'd1421));
		// a block size of zero behaves as one
		plan.push_back(wr(REG_SAMPLE_COUNT, 16'h5A00));
		plan.push_back(smp(12'd2800));
		plan.push_back(smp(12'd2799));
		// on level below off level: a mean meeting both turns the pump on
		plan.push_back(wr(REG_PUMP_ON_LEVEL, 16'hF3E8));
		plan.push_back(wr(REG_PUMP_OFF_LEVEL, 16'h07D0));
		plan.push_back(smp(12'd1500));
		plan.push_back(smp(12'd2500));
		plan.push_back(smp(12'd999));
		// wet point above dry point: the wet test comes first
		plan.push_back(wr(REG_CALIB_WET, 16'hFBB8));
		plan.push_back(wr(REG_CALIB_DRY, 16'h03E8));
		plan.push_back(smp_is(12'd2000, 12'd2000, 7'd100, 1'b1));
		plan.push_back(smp_is(12'd3500, 12'd3500, 7'd0, 1'b1));
		// writes to unused indexes change nothing
		plan.push_back(wr(3'd5, 16'hFFFF));
		plan.push_back(wr(3'd6, 16'h1234));
		plan.push_back(wr(3'd7, 16'h0000));
		// two-sample block with truncation, then a block cut short
		plan.push_back(wr(REG_SAMPLE_COUNT, 16'h0002));
		plan.push_back(smp(12'd4095));
		plan.push_back(smp(12'd4094));
		plan.push_back(smp(12'd7));
		plan.push_back(wr(REG_SAMPLE_COUNT, 16'h0004));
		plan.push_back(smp(12'd100));
		plan.push_back(smp(12'd200));
		plan.push_back(wr(REG_SAMPLE_COUNT, 16'h0002));
		plan.push_back(smp(12'd301));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		after_sample = 1'b0;
		foreach (plan[i]) begin
			row = plan[i];
			if (row.kind == ROW_WRITE) begin
				if (after_sample)
					wait_idle();
				write_reg(row.index, row.data);
				after_sample = 1'b0;
			end else begin
				send_sample(row.data[SAMPLE_W-1:0]);
				if (row.typed) begin
					void'(pending_readings.pop_back());
					pending_readings.push_back(row.want);
				end
				after_sample = 1'b1;
			end
		end

		// random phases, each with fresh registers and its own pacing
		for (int p = 0; p < PHASES; p++) begin
			wait_idle();
			case (p % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
				default: begin send_idle_pct = 11; recv_stall_pct = 11; end
			endcase
			program_phase(p);
			items = (p == 0) ? 255 : 30;
			for (int k = 0; k < items; k++) begin
				// the full-size block runs near full scale to stress the sum
				if (p == 0 && $urandom_range(0, 3) != 0)
					send_sample(FULL_SCALE);
				else
					send_sample(next_sample());
			end
		end

		wait_idle();
		$display("Sent %0d samples and checked %0d block readings", samples_sent,
			readings_checked);
		$display("using %0d register writes over %0d register settings and four pacing modes",
			writes_done, PHASES + 6);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
